>>> hdl/ssq_pkg.sv
// Package for the SPI scan sequencer: payload structs, register indexes,
// command codes and controller/datapath interface types. No dependencies.
package ssq_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        ready_first;
        logic        ready_second;
        logic [15:0] received_word;
        logic [1:0]  setpoint_channel;
        logic [15:0] setpoint_value;
    } req_t;

    typedef struct packed {
        logic        kind;
        logic [1:0]  device;
        logic [2:0]  byte_count;
        logic [31:0] transmit_bytes;
        logic [3:0]  store_offset;
        logic [15:0] store_value;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic        bus_enable;
        logic        adc_first_enable;
        logic        adc_second_enable;
        logic        dac_enable;
        logic        single_ended_mode;
        logic        positive_inputs;
        logic [15:0] ready_timeout;
    } cfg_t;

    localparam logic [CFG_INDEX_W-1:0] REG_BUS_ENABLE        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ADC_FIRST_ENABLE  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ADC_SECOND_ENABLE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DAC_ENABLE        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SINGLE_ENDED      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_POSITIVE_INPUTS   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_READY_TIMEOUT     = 3'd6;

    localparam logic [15:0] READY_TIMEOUT_RST = 16'd1000;

    localparam logic [1:0] OP_POLL     = 2'd0;
    localparam logic [1:0] OP_DONE     = 2'd1;
    localparam logic [1:0] OP_SETPOINT = 2'd2;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STORE = 1'b1;

    localparam logic [1:0] DEV_ADC_FIRST  = 2'd0;
    localparam logic [1:0] DEV_ADC_SECOND = 2'd1;
    localparam logic [1:0] DEV_DAC        = 2'd2;

    localparam logic [2:0] ADC_BYTES = 3'd4;
    localparam logic [2:0] DAC_BYTES = 3'd3;

    // ADC per-device phase
    localparam logic [2:0] PH_INIT      = 3'd0;
    localparam logic [2:0] PH_ARM       = 3'd1;
    localparam logic [2:0] PH_WAIT_AIN0 = 3'd2;
    localparam logic [2:0] PH_READ_AIN0 = 3'd3;
    localparam logic [2:0] PH_WAIT_AIN2 = 3'd4;
    localparam logic [2:0] PH_READ_AIN2 = 3'd5;
    localparam logic [2:0] PH_WAIT_TEMP = 3'd6;
    localparam logic [2:0] PH_READ_TEMP = 3'd7;

    // conversion started by a command
    localparam logic [1:0] CONV_AIN0 = 2'd0;
    localparam logic [1:0] CONV_AIN2 = 2'd1;
    localparam logic [1:0] CONV_TEMP = 2'd2;

    localparam logic [7:0] CMD_AIN0_DIFF = 8'h81;
    localparam logic [7:0] CMD_AIN0_POS  = 8'hC1;
    localparam logic [7:0] CMD_AIN0_NEG  = 8'hD1;
    localparam logic [7:0] CMD_AIN2_DIFF = 8'hB1;
    localparam logic [7:0] CMD_AIN2_POS  = 8'hE1;
    localparam logic [7:0] CMD_AIN2_NEG  = 8'hF1;
    localparam logic [7:0] CMD_TEMP      = 8'h81;
    localparam logic [7:0] CMD_CFG_ADC   = 8'h8B;
    localparam logic [7:0] CMD_CFG_TEMP  = 8'h9B;
    localparam logic [7:0] CMD_FILL      = 8'hFF;
    localparam logic [7:0] DAC_CMD_BASE  = 8'h18;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_VISIT = 3'b010,
        ST_EMIT  = 3'b100
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic visit;
        logic emit_step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic poll_go;
        logic loop_end;
        logic emit_empty;
        logic emit_last;
    } dp_status_t;

    function automatic logic [31:0] adc_command(input logic [1:0] conv,
                                                input logic se,
                                                input logic pos);
        logic [7:0] b0;
        logic [7:0] b1;
        b1 = CMD_CFG_ADC;
        case (conv)
            CONV_AIN0: b0 = se ? (pos ? CMD_AIN0_POS : CMD_AIN0_NEG) : CMD_AIN0_DIFF;
            CONV_AIN2: b0 = se ? (pos ? CMD_AIN2_POS : CMD_AIN2_NEG) : CMD_AIN2_DIFF;
            default:
            begin
                b0 = CMD_TEMP;
                b1 = CMD_CFG_TEMP;
            end
        endcase
        return {b0, b1, CMD_FILL, CMD_FILL};
    endfunction

    function automatic logic [3:0] adc_store_offset(input logic second,
                                                    input logic [2:0] ph);
        logic [3:0] off;
        case (ph)
            PH_READ_AIN0: off = second ? 4'd2 : 4'd0;
            PH_READ_AIN2: off = second ? 4'd3 : 4'd1;
            default:      off = second ? 4'd10 : 4'd9;
        endcase
        return off;
    endfunction

endpackage

>>> hdl/spi_adc_dac_scan_sequencer.sv
// SPI scan sequencer sharing one bus between two ADCs and a four-channel DAC.
// Top level: ties together ssq_cfg_regs, ssq_ctrl and ssq_datapath (ssq_pkg).
//
// Request channel (req_valid/req_stall/req_data): poll, transfer-complete and
// setpoint-write items. A transfer happens when valid is high and stall low.
// Response channel (rsp_valid/rsp_stall/rsp_data): SPI transfer starts and
// reading stores, with last set on the final response of a poll.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_wdata): always ready;
// write only while the sequencer is idle.
//
// Sequence: completion, setpoint and ignored (busy or disabled) poll items are
// accepted in the idle state and leave it idle. A live poll is accepted, then
// visits one to three devices (one device per cycle through the shared visit
// logic), then hands out its buffered responses (up to three) in order, or
// goes back to idle when it has none. req_stall stays high until the last
// response of a poll is taken; a stalled response holds until it is taken.
// Reset: all devices enabled, differential mode, timeout 1000, ADCs in
// their init phase, no setpoints pending, bus idle.
module spi_adc_dac_scan_sequencer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  ssq_pkg::req_t                   req_data,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output ssq_pkg::rsp_t                   rsp_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ssq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ssq_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import ssq_pkg::*;

    cfg_t       cfg;
    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    ssq_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_wdata),
        .cfg      (cfg)
    );

    ssq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .cmd       (cmd)
    );

    ssq_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .req    (req_data),
        .cmd    (cmd),
        .status (status),
        .rsp    (rsp_data)
    );

endmodule

>>> hdl/ssq_cfg_regs.sv
// Configuration register file of the SPI scan sequencer.
// Depends on ssq_pkg.
module ssq_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [ssq_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [ssq_pkg::CFG_DATA_W-1:0]  wr_data,
    output ssq_pkg::cfg_t                  cfg
);
    import ssq_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bus_enable        <= 1'b1;
            cfg_reg.adc_first_enable  <= 1'b1;
            cfg_reg.adc_second_enable <= 1'b1;
            cfg_reg.dac_enable        <= 1'b1;
            cfg_reg.single_ended_mode <= 1'b0;
            cfg_reg.positive_inputs   <= 1'b1;
            cfg_reg.ready_timeout     <= READY_TIMEOUT_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_BUS_ENABLE:        cfg_reg.bus_enable        <= wr_data[0];
                REG_ADC_FIRST_ENABLE:  cfg_reg.adc_first_enable  <= wr_data[0];
                REG_ADC_SECOND_ENABLE: cfg_reg.adc_second_enable <= wr_data[0];
                REG_DAC_ENABLE:        cfg_reg.dac_enable        <= wr_data[0];
                REG_SINGLE_ENDED:      cfg_reg.single_ended_mode <= wr_data[0];
                REG_POSITIVE_INPUTS:   cfg_reg.positive_inputs   <= wr_data[0];
                REG_READY_TIMEOUT:     cfg_reg.ready_timeout     <= wr_data[15:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hdl/ssq_datapath.sv
// Datapath of the SPI scan sequencer: device state, setpoints, one device
// visit per cycle and the result buffer. Depends on ssq_pkg.
module ssq_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  ssq_pkg::cfg_t       cfg,
    input  ssq_pkg::req_t       req,
    input  ssq_pkg::ctrl_cmd_t  cmd,
    output ssq_pkg::dp_status_t status,
    output ssq_pkg::rsp_t       rsp
);
    import ssq_pkg::*;

    logic        busy_reg, busy_next;
    logic [15:0] last_rx_reg, last_rx_next;
    logic [1:0]  pos_reg, pos_next;
    logic [1:0]  start_pos_reg, start_pos_next;
    logic [2:0]  phase_reg [2], phase_next [2];
    logic [15:0] nrc_reg [2], nrc_next [2];
    logic        dac_sending_reg, dac_sending_next;
    logic [1:0]  dac_ch_reg, dac_ch_next;
    logic [15:0] sp_reg [4], sp_next [4];
    logic [3:0]  pend_reg, pend_next;
    logic [1:0]  rdy_reg, rdy_next;
    logic [1:0]  count_reg, count_next;
    logic [1:0]  idx_reg, idx_next;
    rsp_t        buf_reg [3];

    rsp_t        res;
    logic        res_valid;
    logic        released;
    logic        k;
    logic        adc_en;
    logic [2:0]  ph;
    logic [15:0] cnt_inc;
    logic [1:0]  conv;
    logic [1:0]  pos_adv;
    logic [1:0]  pos_after;
    logic        poll_go;

    assign poll_go = (req.opcode == OP_POLL) && cfg.bus_enable && !busy_reg;

    always_comb
    begin
        busy_next        = busy_reg;
        last_rx_next     = last_rx_reg;
        start_pos_next   = start_pos_reg;
        phase_next       = phase_reg;
        nrc_next         = nrc_reg;
        dac_sending_next = dac_sending_reg;
        dac_ch_next      = dac_ch_reg;
        sp_next          = sp_reg;
        pend_next        = pend_reg;
        rdy_next         = rdy_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        res              = '0;
        res_valid        = 1'b0;
        released         = 1'b0;
        k                = pos_reg[0];
        adc_en           = k ? cfg.adc_second_enable : cfg.adc_first_enable;
        ph               = phase_reg[k];
        cnt_inc          = nrc_reg[k] + 16'd1;
        conv             = CONV_AIN0;

        if (cmd.accept)
        begin
            case (req.opcode)
                OP_DONE:
                begin
                    if (busy_reg)
                    begin
                        busy_next    = 1'b0;
                        last_rx_next = req.received_word;
                    end
                end
                OP_SETPOINT:
                begin
                    sp_next[req.setpoint_channel]   = req.setpoint_value;
                    pend_next[req.setpoint_channel] = 1'b1;
                end
                OP_POLL:
                begin
                    if (poll_go)
                    begin
                        start_pos_next = pos_reg;
                        count_next     = 2'd0;
                        idx_next       = 2'd0;
                        rdy_next       = {req.ready_second, req.ready_first};
                    end
                end
                default: ;
            endcase
        end

        if (cmd.visit)
        begin
            case (pos_reg)
                DEV_ADC_FIRST, DEV_ADC_SECOND:
                begin
                    if (!adc_en)
                    begin
                        released = 1'b1;
                    end
                    else
                    begin
                        case (ph)
                            PH_INIT:
                            begin
                                res_valid    = 1'b1;
                                conv         = CONV_AIN0;
                                phase_next[k] = PH_ARM;
                            end
                            PH_ARM:
                            begin
                                nrc_next[k]   = 16'd0;
                                phase_next[k] = PH_WAIT_AIN0;
                                released      = 1'b1;
                            end
                            PH_WAIT_AIN0, PH_WAIT_AIN2, PH_WAIT_TEMP:
                            begin
                                if (rdy_reg[k])
                                    nrc_next[k] = cnt_inc;
                                if (rdy_reg[k] && (cnt_inc <= cfg.ready_timeout))
                                begin
                                    released = 1'b1;
                                end
                                else
                                begin
                                    res_valid     = 1'b1;
                                    phase_next[k] = ph + 3'd1;
                                    case (ph)
                                        PH_WAIT_AIN0: conv = CONV_AIN2;
                                        PH_WAIT_AIN2: conv = CONV_TEMP;
                                        default:      conv = CONV_AIN0;
                                    endcase
                                end
                            end
                            default:
                            begin
                                res.kind         = KIND_STORE;
                                res.device       = pos_reg;
                                res.store_offset = adc_store_offset(k, ph);
                                res.store_value  = last_rx_reg;
                                nrc_next[k]      = 16'd0;
                                phase_next[k]    = (ph == PH_READ_TEMP) ? PH_WAIT_AIN0
                                                                        : ph + 3'd1;
                                released         = 1'b1;
                            end
                        endcase
                        if (res_valid)
                        begin
                            res.kind           = KIND_START;
                            res.device         = pos_reg;
                            res.byte_count     = ADC_BYTES;
                            res.transmit_bytes = adc_command(conv, cfg.single_ended_mode,
                                                             cfg.positive_inputs);
                            busy_next          = 1'b1;
                        end
                        else if (ph[0] && (ph != PH_ARM))
                        begin
                            res_valid = 1'b1;
                        end
                    end
                end
                DEV_DAC:
                begin
                    if (!cfg.dac_enable)
                    begin
                        released = 1'b1;
                    end
                    else if (dac_sending_reg)
                    begin
                        dac_sending_next = 1'b0;
                        released         = 1'b1;
                    end
                    else
                    begin
                        dac_ch_next = dac_ch_reg + 2'd1;
                        if (!pend_reg[dac_ch_reg])
                        begin
                            released = 1'b1;
                        end
                        else
                        begin
                            pend_next[dac_ch_reg] = 1'b0;
                            busy_next             = 1'b1;
                            dac_sending_next      = 1'b1;
                            res_valid             = 1'b1;
                            res.kind              = KIND_START;
                            res.device            = DEV_DAC;
                            res.byte_count        = DAC_BYTES;
                            res.transmit_bytes    = {DAC_CMD_BASE + {6'd0, dac_ch_reg},
                                                     sp_reg[dac_ch_reg], 8'h00};
                        end
                    end
                end
                default:
                begin
                    released = 1'b1;
                end
            endcase
            if (res_valid)
                count_next = count_reg + 2'd1;
        end

        if (cmd.emit_step)
            idx_next = idx_reg + 2'd1;
    end

    assign pos_adv   = (pos_reg >= DEV_DAC) ? DEV_ADC_FIRST : pos_reg + 2'd1;
    assign pos_after = released ? pos_adv : pos_reg;
    assign pos_next  = cmd.visit ? pos_after : pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            last_rx_reg     <= 16'd0;
            pos_reg         <= DEV_ADC_FIRST;
            start_pos_reg   <= DEV_ADC_FIRST;
            phase_reg       <= '{PH_INIT, PH_INIT};
            nrc_reg         <= '{16'd0, 16'd0};
            dac_sending_reg <= 1'b0;
            dac_ch_reg      <= 2'd0;
            sp_reg          <= '{16'd0, 16'd0, 16'd0, 16'd0};
            pend_reg        <= 4'd0;
            rdy_reg         <= 2'd0;
            count_reg       <= 2'd0;
            idx_reg         <= 2'd0;
        end
        else
        begin
            busy_reg        <= busy_next;
            last_rx_reg     <= last_rx_next;
            pos_reg         <= pos_next;
            start_pos_reg   <= start_pos_next;
            phase_reg       <= phase_next;
            nrc_reg         <= nrc_next;
            dac_sending_reg <= dac_sending_next;
            dac_ch_reg      <= dac_ch_next;
            sp_reg          <= sp_next;
            pend_reg        <= pend_next;
            rdy_reg         <= rdy_next;
            count_reg       <= count_next;
            idx_reg         <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.visit && res_valid)
            buf_reg[count_reg] <= res;
    end

    assign status.poll_go    = poll_go;
    assign status.loop_end   = busy_next || (pos_after == start_pos_reg);
    assign status.emit_empty = (count_reg == 2'd0);
    assign status.emit_last  = (idx_reg == (count_reg - 2'd1));

    always_comb
    begin
        rsp      = buf_reg[idx_reg];
        rsp.last = status.emit_last;
    end

endmodule

>>> hdl/ssq_ctrl.sv
// Controller state machine of the SPI scan sequencer: accepts items, runs
// device visits, then hands out buffered results. Depends on ssq_pkg.
module ssq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    input  ssq_pkg::dp_status_t status,
    output ssq_pkg::ctrl_cmd_t  cmd
);
    import ssq_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        req_stall     = 1'b1;
        rsp_valid     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall  = 1'b0;
                cmd.accept = req_valid;
                if (req_valid && status.poll_go)
                    state_next = ST_VISIT;
            end
            ST_VISIT:
            begin
                cmd.visit = 1'b1;
                if (status.loop_end)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                rsp_valid = !status.emit_empty;
                if (status.emit_empty)
                begin
                    state_next = ST_IDLE;
                end
                else if (!rsp_stall)
                begin
                    cmd.emit_step = 1'b1;
                    if (status.emit_last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
